// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared codes and widths for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int OP_W  = 3;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;

	typedef logic [OP_W-1:0]  op_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [ST_W-1:0]  status_t;

	localparam op_t OP_PUSH_FRONT = 3'd0;
	localparam op_t OP_PUSH_BACK  = 3'd1;
	localparam op_t OP_POP_FRONT  = 3'd2;
	localparam op_t OP_POP_BACK   = 3'd3;
	localparam op_t OP_SEARCH     = 3'd4;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

endpackage

// File: rtl/bdq_req_if.sv
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: operation and value, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdq_req_if
	import bdq_pkg::*;
();
	logic valid;
	logic ready;
	op_t  op;
	val_t value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

// File: rtl/bdq_rsp_if.sv
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: pop result, search flag, status and peek fields.
// ----------------------------------------------------------------------------
interface bdq_rsp_if
	import bdq_pkg::*;
#(
	parameter int CW = 11
) ();
	logic          valid;
	logic          ready;
	val_t          result_value;
	logic          found;
	status_t       status;
	val_t          front_value;
	val_t          back_value;
	logic [CW-1:0] held_count;
	logic          is_empty;
	logic          is_full;

	modport source (output valid, output result_value, output found, output status,
		output front_value, output back_value, output held_count, output is_empty,
		output is_full, input ready);
	modport sink   (input valid, input result_value, input found, input status,
		input front_value, input back_value, input held_count, input is_empty,
		input is_full, output ready);
endinterface

// File: rtl/bdq_mem.sv
// ----------------------------------------------------------------------------
// bdq_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdq_mem
	import bdq_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  val_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output val_t          rdata
);

	val_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/bounded_deque_with_search_core.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core
// Deque of 32-bit values in a ring of DEPTH slots with linear search.
// ----------------------------------------------------------------------------
// Push and pop: result register loads in S_FIN; no new item is taken before that.
// Search on a non-empty deque runs in S_SRCH before S_FIN, reading one slot per cycle
//   through the single memory read port; ends early on the first match.
// A result held back by rsp.ready low holds the next item in S_FIN and req.ready low.
// Front and back values are cached in registers; a pop refills one via a read.
// arst_n clears pointers, count and handshake state; slots need no clearing.
module bounded_deque_with_search_core
	import bdq_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
		return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx);
		return (idx == '0) ? AW'(DEPTH - 1) : idx - 1'b1;
	endfunction

	logic [1:0]    state_q;
	logic [AW-1:0] front_idx_q, back_idx_q, ptr_q;
	logic [CW-1:0] count_q, rem_q;
	logic          pend_q;
	val_t          front_val_q, back_val_q, key_q, popped_q;
	op_t           op_q;
	status_t       status_q;
	logic          found_q;

	logic          out_valid_q;
	val_t          out_result_q, out_front_q, out_back_q;
	logic          out_found_q;
	status_t       out_status_q;
	logic [CW-1:0] out_count_q;
	logic          out_empty_q, out_full_q;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	val_t          mem_rdata;

	logic          acc, is_full, is_empty, push_ok, pop_ok;
	logic          hit, load;
	logic          refill_front, refill_back;
	val_t          front_nx, back_nx;

	assign acc      = (state_q == S_IDLE) && req.valid;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign push_ok  = ((req.op == OP_PUSH_FRONT) || (req.op == OP_PUSH_BACK)) && !is_full;
	assign pop_ok   = ((req.op == OP_POP_FRONT) || (req.op == OP_POP_BACK)) && !is_empty;

	assign req.ready = (state_q == S_IDLE);

	assign hit  = (state_q == S_SRCH) && pend_q && (mem_rdata == key_q);
	assign load = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	// Memory port steering
	always_comb begin
		mem_we    = acc && push_ok;
		mem_waddr = (req.op == OP_PUSH_FRONT) ? ring_dec(front_idx_q) : ring_inc(back_idx_q);
		if (state_q == S_SRCH) begin
			mem_re    = !hit && (rem_q != '0);
			mem_raddr = ptr_q;
		end else begin
			mem_re    = acc && pop_ok;
			mem_raddr = (req.op == OP_POP_FRONT) ? ring_inc(front_idx_q) : ring_dec(back_idx_q);
		end
	end

	// Refilled peek values after a successful pop; other ops keep the cache
	assign refill_front = (op_q == OP_POP_FRONT) && (status_q == ST_OK) && (count_q != '0);
	assign refill_back  = (op_q == OP_POP_BACK) && (status_q == ST_OK) && (count_q != '0);
	assign front_nx     = refill_front ? mem_rdata : front_val_q;
	assign back_nx      = refill_back ? mem_rdata : back_val_q;

	bdq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (req.value),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_idx_q <= '0;
			back_idx_q  <= AW'(DEPTH - 1);
			count_q     <= '0;
			ptr_q       <= '0;
			rem_q       <= '0;
			pend_q      <= 1'b0;
			op_q        <= OP_SEARCH;
			status_q    <= ST_OK;
			found_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						op_q     <= req.op;
						found_q  <= 1'b0;
						status_q <= ST_OK;
						state_q  <= S_FIN;
						case (req.op)
							OP_PUSH_FRONT: begin
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									front_idx_q <= ring_dec(front_idx_q);
									count_q     <= count_q + 1'b1;
								end
							end
							OP_PUSH_BACK: begin
								if (is_full) begin
									status_q <= ST_FULL;
								end else begin
									back_idx_q <= ring_inc(back_idx_q);
									count_q    <= count_q + 1'b1;
								end
							end
							OP_POP_FRONT: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else begin
									front_idx_q <= ring_inc(front_idx_q);
									count_q     <= count_q - 1'b1;
								end
							end
							OP_POP_BACK: begin
								if (is_empty) begin
									status_q <= ST_EMPTY;
								end else begin
									back_idx_q <= ring_dec(back_idx_q);
									count_q    <= count_q - 1'b1;
								end
							end
							OP_SEARCH: begin
								if (!is_empty) begin
									ptr_q   <= front_idx_q;
									rem_q   <= count_q;
									pend_q  <= 1'b0;
									state_q <= S_SRCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SRCH: begin
					// compare uses the read data in the cycle after the read is issued
					if (hit) begin
						found_q <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= S_FIN;
					end else if (rem_q != '0) begin
						ptr_q  <= ring_inc(ptr_q);
						rem_q  <= rem_q - 1'b1;
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: value cache, search key, popped value and output fields
	always_ff @(posedge clk) begin
		if (acc) begin
			key_q    <= req.value;
			popped_q <= '0;
			case (req.op)
				OP_PUSH_FRONT: begin
					if (!is_full) begin
						front_val_q <= req.value;
						if (is_empty) begin
							back_val_q <= req.value;
						end
					end
				end
				OP_PUSH_BACK: begin
					if (!is_full) begin
						back_val_q <= req.value;
						if (is_empty) begin
							front_val_q <= req.value;
						end
					end
				end
				OP_POP_FRONT: begin
					if (!is_empty) begin
						popped_q <= front_val_q;
					end
				end
				OP_POP_BACK: begin
					if (!is_empty) begin
						popped_q <= back_val_q;
					end
				end
				default: begin
				end
			endcase
		end
		if (load) begin
			front_val_q  <= front_nx;
			back_val_q   <= back_nx;
			out_result_q <= popped_q;
			out_found_q  <= found_q;
			out_status_q <= status_q;
			out_front_q  <= (count_q == '0) ? '0 : front_nx;
			out_back_q   <= (count_q == '0) ? '0 : back_nx;
			out_count_q  <= count_q;
			out_empty_q  <= (count_q == '0);
			out_full_q   <= (count_q == CW'(DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.result_value = out_result_q;
	assign rsp.found        = out_found_q;
	assign rsp.status       = out_status_q;
	assign rsp.front_value  = out_front_q;
	assign rsp.back_value   = out_back_q;
	assign rsp.held_count   = out_count_q;
	assign rsp.is_empty     = out_empty_q;
	assign rsp.is_full      = out_full_q;

	// Assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && push_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not grow count");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pop_ok |=> count_q == $past(count_q) - 1'b1)
		else $error("pop did not shrink count");

	a_srch_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SRCH |-> !mem_we && count_q == $past(count_q))
		else $error("state changed during search");

	a_err_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_OK |-> out_result_q == '0 && !out_found_q)
		else $error("error item carries data");

endmodule

// File: test/bounded_deque_with_search_core_tb.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search_core_tb
// Self-checking bench for the ring-buffer deque with linear search. A
// scoreboard keeps its own copy of the ring, predicts every reply when an item
// is accepted, and compares the replies field by field in order. Stimulus runs
// a short directed list, then random push/pop/search traffic under several
// idle and stall mixes, a long reply hold-off, and one fill to full followed
// by a partial drain.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bdq_pkg::*;

	localparam int DEPTH     = 1024;
	localparam int CW        = 11;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		val_t          result_value;
		logic          found;
		status_t       status;
		val_t          front_value;
		val_t          back_value;
		logic [CW-1:0] held_count;
		logic          is_empty;
		logic          is_full;
	} deque_reply_t;

	class deque_checker;
		val_t         ring [DEPTH];
		int unsigned  head;
		int unsigned  held;
		deque_reply_t replies_due [$];
		int           errors;

		function new();
			head   = 0;
			held   = 0;
			errors = 0;
		endfunction

		function val_t at(int unsigned offset);
			return ring[(head + offset) % DEPTH];
		endfunction

		function val_t held_value();
			return at($urandom_range(held - 1));
		endfunction

		function void note_item(op_t op, val_t v);
			deque_reply_t r;
			r = '0;
			case (op)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (held == DEPTH) begin
						r.status = ST_FULL;
					end else if (op == OP_PUSH_FRONT) begin
						head = (head + DEPTH - 1) % DEPTH;
						ring[head] = v;
						held++;
					end else begin
						ring[(head + held) % DEPTH] = v;
						held++;
					end
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else if (op == OP_POP_FRONT) begin
						r.result_value = ring[head];
						head = (head + 1) % DEPTH;
						held--;
					end else begin
						r.result_value = at(held - 1);
						held--;
					end
				end
				OP_SEARCH: begin
					for (int unsigned i = 0; i < held && !r.found; i++)
						r.found = (at(i) == v);
				end
				default: begin
				end
			endcase
			if (held != 0) begin
				r.front_value = ring[head];
				r.back_value  = at(held - 1);
			end
			r.held_count = CW'(held);
			r.is_empty   = (held == 0);
			r.is_full    = (held == DEPTH);
			replies_due.push_back(r);
		endfunction

		task flag_mismatch(string what);
			errors++;
			if (errors <= 60)
				$display("%0t ns  mismatch: %s", $time, what);
		endtask

		task check_reply(deque_reply_t got);
			deque_reply_t want;
			if (replies_due.size() == 0) begin
				flag_mismatch("reply with no item outstanding");
				return;
			end
			want = replies_due.pop_front();
			if (got.result_value !== want.result_value)
				flag_mismatch($sformatf("result_value %h, want %h",
					got.result_value, want.result_value));
			if (got.found !== want.found)
				flag_mismatch($sformatf("found %b, want %b", got.found, want.found));
			if (got.status !== want.status)
				flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.front_value !== want.front_value)
				flag_mismatch($sformatf("front_value %h, want %h",
					got.front_value, want.front_value));
			if (got.back_value !== want.back_value)
				flag_mismatch($sformatf("back_value %h, want %h",
					got.back_value, want.back_value));
			if (got.held_count !== want.held_count)
				flag_mismatch($sformatf("held_count %0d, want %0d",
					got.held_count, want.held_count));
			if (got.is_empty !== want.is_empty)
				flag_mismatch($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
			if (got.is_full !== want.is_full)
				flag_mismatch($sformatf("is_full %b, want %b", got.is_full, want.is_full));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   rsp_stall_pct;
	int   hold_requests;

	deque_checker sb;

	bdq_req_if req_if ();
	bdq_rsp_if #(.CW(CW)) rsp_if ();

	bounded_deque_with_search_core #(
		.DEPTH(DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic val_t pool_value();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return 32'h0000_0001;
			4: return 32'hA5A5_5A5A;
			default: return 32'h5A5A_A5A5;
		endcase
	endfunction

	function automatic val_t pick_value();
		if ($urandom_range(1) == 0)
			return pool_value();
		return $urandom();
	endfunction

	function automatic val_t search_target();
		if (sb.held != 0 && $urandom_range(99) < 45)
			return sb.held_value();
		return pick_value();
	endfunction

	task automatic set_idle(int src_pct, int stall_pct);
		src_idle_pct  = src_pct;
		rsp_stall_pct = stall_pct;
	endtask

	// valid stays high from one item to the next unless a gap is drawn
	task automatic send_item(op_t op, val_t v);
		while ($urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op    <= op;
		req_if.value <= v;
		do begin
			@(posedge clk);
		end while (req_if.ready !== 1'b1);
		sb.note_item(op, v);
	endtask

	task automatic directed_items();
		send_item(OP_POP_FRONT, '1);
		send_item(OP_POP_BACK, '0);
		send_item(OP_SEARCH, '0);
		send_item(op_t'(OP_SEARCH + 3'd1), '1);
		send_item(op_t'(OP_SEARCH + 3'd2), '0);
		send_item(op_t'(OP_SEARCH + 3'd3), 32'h1234_5678);
		send_item(OP_PUSH_FRONT, '0);
		send_item(OP_SEARCH, '0);
		send_item(OP_PUSH_BACK, '1);
		send_item(OP_PUSH_FRONT, 32'h8000_0000);
		send_item(OP_PUSH_BACK, 32'h0000_0001);
		send_item(OP_SEARCH, '1);
		send_item(OP_SEARCH, 32'h0000_0001);
		send_item(OP_SEARCH, 32'h1234_5678);
		send_item(op_t'(OP_SEARCH + 3'd3), '1);
		send_item(OP_POP_BACK, '1);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_POP_FRONT, 32'hDEAD_BEEF);
		// last entry leaves; front position stays where it was
		send_item(OP_POP_BACK, '0);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_PUSH_BACK, 32'hA5A5_5A5A);
		send_item(OP_PUSH_FRONT, 32'h5A5A_A5A5);
		send_item(OP_POP_FRONT, '0);
		send_item(OP_POP_BACK, '0);
	endtask

	task automatic random_walk(int n);
		int roll;
		for (int k = 0; k < n; k++) begin
			roll = $urandom_range(99);
			if (roll < 22)
				send_item(OP_PUSH_FRONT, pick_value());
			else if (roll < 44)
				send_item(OP_PUSH_BACK, pick_value());
			else if (roll < 62)
				send_item(OP_POP_FRONT, $urandom());
			else if (roll < 80)
				send_item(OP_POP_BACK, $urandom());
			else if (roll < 96)
				send_item(OP_SEARCH, search_target());
			else
				send_item(op_t'(OP_SEARCH + $urandom_range(3, 1)), $urandom());
		end
	endtask

	// replies held off while pushes keep coming, so the input side backs up
	task automatic pressure_burst();
		hold_requests++;
		for (int k = 0; k < 40; k++)
			send_item($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_value());
	endtask

	task automatic fill_and_drain();
		val_t v;
		while (sb.held != DEPTH) begin
			v = ($urandom_range(99) < 30) ? pool_value() : $urandom();
			if ($urandom_range(99) < 2)
				send_item(OP_SEARCH, search_target());
			else
				send_item($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, v);
		end
		send_item(OP_PUSH_FRONT, '1);
		send_item(OP_PUSH_BACK, '0);
		send_item(OP_SEARCH, sb.at(DEPTH - 1));
		send_item(OP_SEARCH, $urandom());
		send_item(OP_POP_FRONT, '0);
		send_item(OP_PUSH_BACK, $urandom());
		send_item(OP_PUSH_BACK, $urandom());
		repeat (40) begin
			if ($urandom_range(99) < 3)
				send_item(OP_SEARCH, search_target());
			else
				send_item($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, $urandom());
		end
	endtask

	initial begin
		sb            = new();
		hold_requests = 0;
		arst_n        = 1'b0;
		req_if.valid  = 1'b0;
		req_if.op     = OP_SEARCH;
		req_if.value  = '0;
		set_idle(0, 0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();

		pressure_burst();
		random_walk(50);
		set_idle(76, 0);
		random_walk(50);
		set_idle(0, 76);
		random_walk(50);
		set_idle(13, 13);
		random_walk(50);
		fill_and_drain();
		set_idle(0, 0);
		random_walk(30);

		req_if.valid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : reply_side
		int           served;
		int           stall_left;
		deque_reply_t got;
		served       = 0;
		stall_left   = 0;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (served != hold_requests) begin
				served     = hold_requests;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				got.result_value = rsp_if.result_value;
				got.found        = rsp_if.found;
				got.status       = rsp_if.status;
				got.front_value  = rsp_if.front_value;
				got.back_value   = rsp_if.back_value;
				got.held_count   = rsp_if.held_count;
				got.is_empty     = rsp_if.is_empty;
				got.is_full      = rsp_if.is_full;
				sb.check_reply(got);
			end
		end
	end

	initial begin
		#100ms;
		$display("Verification failed");
		$finish;
	end

endmodule
